### design/bea_pkg.sv
// package: widths, register indexes and per-button state type for the button block
`default_nettype none

package bea_pkg;

  localparam int BUTTONS = 6;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] HOLD_DELAY_RST    = CFG_W'(500);
  localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = CFG_W'(100);

  localparam int IN_W        = BUTTONS + TIME_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 4 * BUTTONS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] last_fire;
    logic              fired;
  } btn_state_t;

endpackage

`default_nettype wire

### design/button_edge_and_autorepeat.sv
// top level: button edge detector with typematic auto-repeat
// 2 register stages: the input register, then the result register
// one item per cycle when not stalled; per-button compares all sit in one stage
// a waiting result does not block the input register, so one more item is taken
// reset (rst, synchronous): pipeline empty, button history and timers cleared,
// hold delay 500 ms and repeat period 100 ms
`default_nettype none

module button_edge_and_autorepeat
  import bea_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // button_bits, now_ms, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // level_bits, press_edge_bits, release_edge_bits, repeat_fire_bits, zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  logic [CFG_W-1:0]   hold_delay_ms;
  logic [CFG_W-1:0]   repeat_period_ms;

  logic               in_valid;
  logic [BUTTONS-1:0] in_buttons;
  logic [TIME_W-1:0]  in_now;

  logic               out_valid;
  logic [OUT_W-1:0]   out_data;

  logic [BUTTONS-1:0] prev_levels;
  btn_state_t         btn_state      [BUTTONS];
  btn_state_t         btn_state_next [BUTTONS];
  logic [BUTTONS-1:0] fire;
  logic [BUTTONS-1:0] press;
  logic [BUTTONS-1:0] release_bits;
  logic               advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);

  assign press        = in_buttons & ~prev_levels;
  assign release_bits = prev_levels & ~in_buttons;

  for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
    bea_button u_button (
      .cur              (in_buttons[i]),
      .prev             (prev_levels[i]),
      .now_ms           (in_now),
      .hold_delay_ms    (hold_delay_ms),
      .repeat_period_ms (repeat_period_ms),
      .state            (btn_state[i]),
      .fire             (fire[i]),
      .state_next       (btn_state_next[i])
    );
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_delay_ms    <= HOLD_DELAY_RST;
      repeat_period_ms <= REPEAT_PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HOLD_DELAY) begin
        hold_delay_ms <= cfg_data;
      end else if (cfg_index == CFG_REPEAT_PERIOD) begin
        repeat_period_ms <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_buttons <= s_axis_tdata[BUTTONS-1:0];
      in_now     <= s_axis_tdata[IN_W-1:BUTTONS];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {fire, release_bits, press, in_buttons};
    end
  end

  // button history
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        btn_state[i] <= '0;
      end
    end else if (advance) begin
      prev_levels <= in_buttons;
      for (int i = 0; i < BUTTONS; i++) begin
        btn_state[i] <= btn_state_next[i];
      end
    end
  end

endmodule

`default_nettype wire

### design/bea_button.sv
// one button: hold-delay and repeat-interval check with next state
`default_nettype none

module bea_button
  import bea_pkg::*;
(
  input  wire logic              cur,
  input  wire logic              prev,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [CFG_W-1:0]  hold_delay_ms,
  input  wire logic [CFG_W-1:0]  repeat_period_ms,
  input  wire btn_state_t        state,
  output logic                   fire,
  output btn_state_t             state_next
);

  logic [TIME_W-1:0] press_eff;
  logic [TIME_W-1:0] held_ms;
  logic [TIME_W-1:0] since_fire_ms;
  logic              held_long;
  logic              period_up;

  always_comb begin
    press_eff     = (cur && !prev) ? now_ms : state.press_time;
    held_ms       = now_ms - press_eff;
    since_fire_ms = now_ms - state.last_fire;
    held_long     = held_ms >= {{(TIME_W-CFG_W){1'b0}}, hold_delay_ms};
    period_up     = (repeat_period_ms != '0) &&
                    (since_fire_ms >= {{(TIME_W-CFG_W){1'b0}}, repeat_period_ms});
    fire          = cur && held_long && (!state.fired || period_up);

    if (!cur) begin
      state_next = '0;
    end else begin
      state_next.press_time = press_eff;
      state_next.last_fire  = fire ? now_ms : state.last_fire;
      state_next.fired      = state.fired | fire;
    end
  end

endmodule

`default_nettype wire

### design/bea_checker.sv
// port-level checks for the button block, bound to the top level
`default_nettype none

module bea_checker
  import bea_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [BUTTONS-1:0] level;
  logic [BUTTONS-1:0] press;
  logic [BUTTONS-1:0] rel;
  logic [BUTTONS-1:0] fire;

  assign level = m_axis_tdata[BUTTONS-1:0];
  assign press = m_axis_tdata[2*BUTTONS-1:BUTTONS];
  assign rel   = m_axis_tdata[3*BUTTONS-1:2*BUTTONS];
  assign fire  = m_axis_tdata[4*BUTTONS-1:3*BUTTONS];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_edges_match_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((press & ~level) == '0) && ((rel & level) == '0))
    else $error("edge bits disagree with levels");

  a_fire_needs_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (fire & ~level) == '0)
    else $error("repeat fire on a released button");

endmodule

bind button_edge_and_autorepeat bea_checker u_bea_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### verif/tb.sv
// testbench: button edge and auto-repeat block, directed and random samples checked in order
module tb;
  import bea_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [BUTTONS-1:0] fire_bits;
    logic [BUTTONS-1:0] rel_bits;
    logic [BUTTONS-1:0] press_bits;
    logic [BUTTONS-1:0] level_bits;
  } key_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  // predictor state
  logic [CFG_W-1:0]   hold_delay;
  logic [CFG_W-1:0]   repeat_period;
  logic [BUTTONS-1:0] prev_levels;
  btn_state_t         key_hist [BUTTONS];

  key_result_t    expected_keys [$];
  int unsigned    fail_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    tx_gap_pct = 0;
  int unsigned    rx_stall_pct = 0;

  button_edge_and_autorepeat u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic void reset_predictor();
    hold_delay    = HOLD_DELAY_RST;
    repeat_period = REPEAT_PERIOD_RST;
    prev_levels   = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      key_hist[i] = '0;
    end
  endfunction

  function automatic key_result_t predict_keys(logic [BUTTONS-1:0] btn, logic [TIME_W-1:0] now);
    key_result_t res;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_fire;
    logic go;
    res.level_bits = btn;
    res.press_bits = btn & ~prev_levels;
    res.rel_bits   = prev_levels & ~btn;
    res.fire_bits  = '0;
    prev_levels = btn;
    for (int i = 0; i < BUTTONS; i++) begin
      if (res.press_bits[i]) begin
        key_hist[i].press_time = now;
      end
      if (!btn[i]) begin
        key_hist[i] = '0;
      end else begin
        held = now - key_hist[i].press_time;
        since_fire = now - key_hist[i].last_fire;
        go = 1'b0;
        if (held >= TIME_W'(hold_delay)) begin
          if (!key_hist[i].fired) begin
            go = 1'b1;
          end else if (repeat_period != '0 && since_fire >= TIME_W'(repeat_period)) begin
            go = 1'b1;
          end
        end
        if (go) begin
          key_hist[i].last_fire = now;
          key_hist[i].fired = 1'b1;
          res.fire_bits[i] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [BUTTONS-1:0] exp_v, logic [BUTTONS-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result check, config tracking and prediction on each accepted transfer
  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = key_result_t'(m_axis_tdata[OUT_W-1:0]);
        if (expected_keys.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_keys.pop_front();
          check_field("level_bits", want.level_bits, got.level_bits);
          check_field("press_edge_bits", want.press_bits, got.press_bits);
          check_field("release_edge_bits", want.rel_bits, got.rel_bits);
          check_field("repeat_fire_bits", want.fire_bits, got.fire_bits);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOLD_DELAY: hold_delay = cfg_data;
          CFG_REPEAT_PERIOD: repeat_period = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_keys.push_back(predict_keys(s_axis_tdata[BUTTONS-1:0],
                                             s_axis_tdata[BUTTONS +: TIME_W]));
      end
    end
  end

  task automatic send_sample(logic [BUTTONS-1:0] btn, logic [TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_TDATA_W'({now, btn});
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_keys.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // only called once the pipeline has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_timing(logic [CFG_W-1:0] hold, logic [CFG_W-1:0] period);
    wait_drained();
    write_reg(CFG_HOLD_DELAY, hold);
    write_reg(CFG_REPEAT_PERIOD, period);
  endtask

  task automatic test_directed_cases();
    // reset timing: 500 ms delay, 100 ms period
    send_sample(6'h00, 32'h0000_0000);
    send_sample(6'h3f, 32'd1000);
    send_sample(6'h3f, 32'd1499);
    send_sample(6'h3f, 32'd1500);
    send_sample(6'h3f, 32'd1599);
    send_sample(6'h3f, 32'd1600);
    send_sample(6'h15, 32'd1650);
    send_sample(6'h2a, 32'd1700);
    send_sample(6'h00, 32'hffff_ffff);
    // zero delay fires on the press edge, zero period fires once
    set_timing(16'h0000, 16'h0000);
    send_sample(6'h3f, 32'hffff_ffff);
    send_sample(6'h3f, 32'h0000_0005);
    send_sample(6'h3f, 32'h0000_0000);
    send_sample(6'h00, 32'h0000_0001);
    send_sample(6'h01, 32'h0000_0001);
    // time stepping backwards looks like a long hold
    set_timing(16'd10, 16'hffff);
    send_sample(6'h00, 32'd100);
    send_sample(6'h01, 32'd100);
    send_sample(6'h01, 32'd50);
    send_sample(6'h01, 32'd49);
    send_sample(6'h01, 32'd49);
    // wrap of the timestamp through zero
    send_sample(6'h3e, 32'hffff_fff0);
    send_sample(6'h3e, 32'h0000_0004);
    set_timing(16'hffff, 16'h0001);
    send_sample(6'h3e, 32'hffff_0000);
    send_sample(6'h3e, 32'h0000_ffff);
    send_sample(6'h3e, 32'h0001_0000);
  endtask

  task automatic random_sweep(int unsigned items_per_setting);
    logic [CFG_W-1:0]   hold;
    logic [CFG_W-1:0]   period;
    logic [BUTTONS-1:0] btn;
    logic [TIME_W-1:0]  now;
    int unsigned        scale;
    int unsigned        r;
    for (int c = 0; c < 8; c++) begin
      case (c)
        0: begin hold = 16'h0000; period = 16'h0000; end
        1: begin hold = 16'hffff; period = 16'hffff; end
        2: begin hold = HOLD_DELAY_RST; period = REPEAT_PERIOD_RST; end
        3: begin hold = 16'h0000; period = 16'h0001; end
        4: begin hold = 16'hffff; period = 16'h0000; end
        5: begin hold = 16'd3; period = 16'd2; end
        6: begin hold = 16'd1; period = 16'hffff; end
        default: begin
          hold = CFG_W'($urandom_range(65535));
          period = CFG_W'($urandom_range(65535));
        end
      endcase
      set_timing(hold, period);
      scale = ((hold > period) ? hold : period) + 4;
      btn = BUTTONS'($urandom);
      now = $urandom;
      for (int n = 0; n < items_per_setting; n++) begin
        r = $urandom_range(99);
        if (r < 5) begin
          btn = BUTTONS'($urandom);
        end else begin
          for (int b = 0; b < BUTTONS; b++) begin
            if ($urandom_range(99) < 8) begin
              btn[b] = ~btn[b];
            end
          end
        end
        r = $urandom_range(99);
        if (r < 60) begin
          now = now + $urandom_range(scale / 8 + 1);
        end else if (r < 85) begin
          now = now + $urandom_range(2 * scale);
        end else if (r < 93) begin
          now = $urandom;
        end
        send_sample(btn, now);
      end
    end
  endtask

  task automatic test_random_receiver_stalls();
    tx_gap_pct = 6;
    rx_stall_pct = 87;
    random_sweep(80);
  endtask

  task automatic test_random_sender_gaps();
    tx_gap_pct = 87;
    rx_stall_pct = 6;
    random_sweep(80);
  endtask

  task automatic test_random_full_rate();
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    random_sweep(80);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_HOLD_DELAY;
    cfg_data      = '0;
    reset_predictor();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_random_receiver_stalls();
    test_random_sender_gaps();
    test_random_full_rate();
    wait_drained();

    if (fail_count == 0 && expected_keys.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
